FILE: sv/hgfa_pkg.sv
package hgfa_pkg;

    localparam int MAX_BUCKETS   = 1024;
    localparam int MAX_GROUPS    = 1024;
    localparam int KEY_BYTES_MAX = 8;
    localparam int HASH_SHIFT    = 3;

    localparam int BKT_W = $clog2(MAX_BUCKETS);
    localparam int GRP_W = $clog2(MAX_GROUPS);
    localparam int CNT_W = GRP_W + 1;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_BYTES    = 2'd0;
    localparam logic [1:0] REG_BUCKET_COUNT = 2'd1;
    localparam logic [1:0] REG_GROUP_LIMIT  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_MATCHED = 2'd0;
    localparam logic [1:0] ST_ADDED   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic FUNC_FIND = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] key;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] group_index;
    } out_item_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic             clear;
        logic [63:0]      key;
        logic [63:0]      mask;
        logic [BKT_W-1:0] bucket;
    } cmd_t;

endpackage

FILE: sv/hgfa_front.sv
module hgfa_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hgfa_pkg::in_item_t in_data,
    input  logic [3:0]         key_bytes,
    input  logic [10:0]        bucket_count,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output hgfa_pkg::cmd_t     cmd
);
    import hgfa_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic        clear_reg;
    logic [63:0] key_reg;
    logic [3:0]  nb_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] hash_reg;
    logic [10:0] nbk_reg;
    logic [5:0]  mstep_reg;
    logic [31:0] rem_reg;
    logic [63:0] mask;
    logic [3:0]  nb_eff;
    logic [10:0] nbk_eff;
    logic [31:0] hash_step;
    logic [7:0]  cur_byte;
    logic [11:0] trial;
    logic [11:0] rsh;

    // Clamp the configured sizes.
    always_comb
    begin
        nb_eff = key_bytes;
        if (key_bytes == 4'd0)
            nb_eff = 4'd1;
        else if (key_bytes > 4'(KEY_BYTES_MAX))
            nb_eff = 4'(KEY_BYTES_MAX);
        nbk_eff = bucket_count;
        if (bucket_count == 11'd0)
            nbk_eff = 11'd1;
        else if (bucket_count > 11'(MAX_BUCKETS))
            nbk_eff = 11'(MAX_BUCKETS);
    end

    // One key byte folded per cycle.
    assign cur_byte  = key_reg[8*cnt_reg[2:0] +: 8];
    assign hash_step = (hash_reg ^ {24'd0, cur_byte}) << HASH_SHIFT;

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < 8; i++)
            if (4'(i) < nb_reg)
                mask[8*i +: 8] = 8'hFF;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid)
                state_next = in_data.func == FUNC_CLEAR ? F_OUT : F_HASH;
            F_HASH: if (cnt_reg + 4'd1 == nb_reg) state_next = F_MOD;
            F_MOD:  if (mstep_reg == 6'd31) state_next = F_OUT;
            F_OUT:  if (cmd_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Restoring remainder step: one hash bit per cycle.
    assign rsh   = {rem_reg[10:0], hash_reg[31 - mstep_reg[4:0]]};
    assign trial = rsh - {1'b0, nbk_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                clear_reg <= in_data.func;
                key_reg   <= in_data.key;
                nb_reg    <= nb_eff;
                nbk_reg   <= nbk_eff;
                cnt_reg   <= 4'd0;
                hash_reg  <= '0;
                mstep_reg <= '0;
                rem_reg   <= '0;
            end
            F_HASH:
            begin
                hash_reg <= hash_step;
                cnt_reg  <= cnt_reg + 4'd1;
            end
            F_MOD:
            begin
                rem_reg   <= trial[11] ? {20'd0, rsh} : {20'd0, trial};
                mstep_reg <= mstep_reg + 6'd1;
            end
            F_OUT: ;
            default: ;
        endcase
    end

    assign in_ready     = state_reg == F_IDLE;
    assign cmd_valid    = state_reg == F_OUT;
    assign cmd.clear    = clear_reg;
    assign cmd.key      = key_reg;
    assign cmd.mask     = mask;
    assign cmd.bucket   = rem_reg[BKT_W-1:0];

endmodule

FILE: sv/hgfa_fifo.sv
module hgfa_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  hgfa_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output hgfa_pkg::cmd_t rd_data
);
    import hgfa_pkg::*;

    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_fire, rd_fire;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = slot_reg[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // Two-entry queue between classification and table walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_fire) wp_reg <= ~wp_reg;
            if (rd_fire) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_fire) - 2'(rd_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            slot_reg[wp_reg] <= wr_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !wr_fire)
        else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers inconsistent");
`endif

endmodule

FILE: sv/hgfa_back.sv
module hgfa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  hgfa_pkg::cmd_t      cmd,
    input  logic [10:0]         group_limit,
    output logic                out_valid,
    input  logic                out_ready,
    output hgfa_pkg::out_item_t out_data
);
    import hgfa_pkg::*;

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_CLRSW  = 4'd1;
    localparam logic [3:0] B_HEADRD = 4'd2;
    localparam logic [3:0] B_HEADWT = 4'd3;
    localparam logic [3:0] B_GRPRD  = 4'd4;
    localparam logic [3:0] B_GRPWT  = 4'd5;
    localparam logic [3:0] B_CMP    = 4'd6;
    localparam logic [3:0] B_ADD    = 4'd7;
    localparam logic [3:0] B_DONE   = 4'd8;
    localparam logic [3:0] B_LINK   = 4'd9;

    // Bucket heads: valid flag plus group index; group memories.
    logic [GRP_W:0]   head_mem [MAX_BUCKETS];
    logic [63:0]      key_mem  [MAX_GROUPS];
    logic [GRP_W:0]   next_mem [MAX_GROUPS];

    logic [3:0]       state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             swept_reg;
    logic [BKT_W:0]   sweep_reg;
    cmd_t             cmd_reg;
    logic [GRP_W:0]   head_q_reg;
    logic [GRP_W:0]   next_q_reg;
    logic [63:0]      key_q_reg;
    logic [GRP_W-1:0] cur_reg;
    logic             have_tail_reg;
    logic [GRP_W-1:0] tail_reg;
    out_item_t        res_reg;
    logic             out_valid_reg;
    logic [CNT_W-1:0] limit;
    logic             room;
    logic [GRP_W-1:0] link_idx;

    always_comb
    begin
        limit = group_limit;
        if (group_limit > 11'(MAX_GROUPS))
            limit = CNT_W'(MAX_GROUPS);
    end

    // A new group fits only below the effective limit.
    assign room     = count_reg < limit;
    // The group added just before the tail link is written.
    assign link_idx = GRP_W'(count_reg - 1'b1);

    assign cmd_ready = state_reg == B_IDLE && swept_reg && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // Registered memory reads.
    always_ff @(posedge clk)
    begin
        head_q_reg <= head_mem[cmd_reg.bucket];
        key_q_reg  <= key_mem[cur_reg];
        next_q_reg <= next_mem[cur_reg];
    end

    // Memory writes: sweep, head link, new group, then tail link.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLRSW)
            head_mem[sweep_reg[BKT_W-1:0]] <= '0;
        else if (state_reg == B_ADD && room && !have_tail_reg)
            head_mem[cmd_reg.bucket] <= {1'b1, count_reg[GRP_W-1:0]};
        if (state_reg == B_ADD && room)
        begin
            key_mem[count_reg[GRP_W-1:0]]  <= cmd_reg.key;
            next_mem[count_reg[GRP_W-1:0]] <= '0;
        end
        else if (state_reg == B_LINK)
            next_mem[tail_reg] <= {1'b1, link_idx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLRSW;
            swept_reg     <= 1'b0;
            sweep_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            have_tail_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                    if (cmd_valid && cmd_ready)
                    begin
                        cmd_reg       <= cmd;
                        have_tail_reg <= 1'b0;
                        if (cmd.clear == FUNC_CLEAR)
                        begin
                            sweep_reg <= '0;
                            count_reg <= '0;
                            state_reg <= B_CLRSW;
                        end
                        else
                            state_reg <= B_HEADRD;
                    end
                B_CLRSW:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (BKT_W+1)'(MAX_BUCKETS - 1))
                    begin
                        if (swept_reg)
                        begin
                            res_reg       <= '{status: ST_FULL, group_index: '0};
                            out_valid_reg <= 1'b1;
                        end
                        swept_reg <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                B_HEADRD: state_reg <= B_HEADWT;
                B_HEADWT:
                    if (head_q_reg[GRP_W])
                    begin
                        cur_reg   <= head_q_reg[GRP_W-1:0];
                        state_reg <= B_GRPRD;
                    end
                    else
                        state_reg <= B_ADD;
                B_GRPRD: state_reg <= B_GRPWT;
                B_GRPWT: state_reg <= B_CMP;
                B_CMP:
                    if (((key_q_reg ^ cmd_reg.key) & cmd_reg.mask) == 64'd0)
                    begin
                        res_reg       <= '{status: ST_MATCHED,
                                           group_index: 10'(cur_reg)};
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        have_tail_reg <= 1'b1;
                        tail_reg      <= cur_reg;
                        if (next_q_reg[GRP_W])
                        begin
                            cur_reg   <= next_q_reg[GRP_W-1:0];
                            state_reg <= B_GRPRD;
                        end
                        else
                            state_reg <= B_ADD;
                    end
                B_ADD:
                begin
                    out_valid_reg <= 1'b1;
                    if (!room)
                    begin
                        res_reg   <= '{status: ST_FULL, group_index: '0};
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        res_reg   <= '{status: ST_ADDED,
                                       group_index: 10'(count_reg)};
                        count_reg <= count_reg + 1'b1;
                        state_reg <= have_tail_reg ? B_LINK : B_IDLE;
                    end
                end
                B_LINK: state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_GROUPS))
        else $error("group count beyond capacity");
    a_no_cmd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLRSW |-> !cmd_ready)
        else $error("command taken during clear sweep");
    a_add_bumps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ADD && count_reg < limit |=> count_reg == $past(count_reg) + 1'b1)
        else $error("group count not advanced on add");
`endif

endmodule

FILE: sv/hash_group_find_or_add.sv
// Flow: a find is accepted, hashed a key byte at a time, reduced by the bucket modulus
// and queued; a clear is queued at once. The back end starts, reads the bucket head,
// reads and compares each chain entry walked and, on a miss, adds a group and links it in.
// Overlap: front and back overlap through a two-entry queue; with short chains the
// front end sets the pace; a clear sweeps all 1024 bucket heads.
// Reset: asynchronous active low; a 1024-head sweep runs first; regs 8/1024/1024.
module hash_group_find_or_add (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hgfa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hgfa_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data
);
    import hgfa_pkg::*;

    logic [3:0]  key_bytes_reg;
    logic [10:0] bucket_count_reg;
    logic [10:0] group_limit_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    cmd_t        f_cmd, b_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg    <= 4'd8;
            bucket_count_reg <= 11'd1024;
            group_limit_reg  <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_BYTES:    key_bytes_reg    <= cfg_data[3:0];
                REG_BUCKET_COUNT: bucket_count_reg <= cfg_data;
                REG_GROUP_LIMIT:  group_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    hgfa_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .key_bytes(key_bytes_reg), .bucket_count(bucket_count_reg),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    hgfa_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
    );

    hgfa_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
        .group_limit(group_limit_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
